// ===== hw/rtl/lts_pkg.sv =====
`timescale 1ns / 1ps

package lts_pkg;

	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 16;

	typedef enum logic [CfgIndexW-1:0] {
		REG_LEFT_THRESHOLD  = 3'd0,
		REG_RIGHT_THRESHOLD = 3'd1,
		REG_DARK_LEVEL      = 3'd2,
		REG_STOP_DISTANCE   = 3'd3,
		REG_CORNER_TIME     = 3'd4,
		REG_FINISH_TIME     = 3'd5,
		REG_SHADOW_TIME     = 3'd6,
		REG_MOTOR_FLIP      = 3'd7
	} reg_index_t;

	typedef enum logic [2:0] {
		DRIVE_FINISH   = 3'd0,
		DRIVE_OBSTACLE = 3'd1,
		DRIVE_SHADOW   = 3'd2,
		DRIVE_WAITING  = 3'd3,
		DRIVE_RUNNING  = 3'd4
	} drive_state_t;

	typedef enum logic [1:0] {
		SIDE_NONE  = 2'd0,
		SIDE_LEFT  = 2'd1,
		SIDE_RIGHT = 2'd2
	} side_t;

	// Motor commands before trim and flip
	typedef enum logic [2:0] {
		CMD_STOP,
		CMD_CRUISE,
		CMD_SLOW,
		CMD_FAST,
		CMD_PIVOT_FWD,
		CMD_PIVOT_REV
	} motor_cmd_t;

	localparam logic [31:0] BEEP_GAP = 32'd800;

	localparam logic [9:0]  RST_LEFT_THRESHOLD  = 10'd35;
	localparam logic [9:0]  RST_RIGHT_THRESHOLD = 10'd30;
	localparam logic [9:0]  RST_DARK_LEVEL      = 10'd850;
	localparam logic [9:0]  RST_STOP_DISTANCE   = 10'd15;
	localparam logic [15:0] RST_CORNER_TIME     = 16'd120;
	localparam logic [15:0] RST_FINISH_TIME     = 16'd100;
	localparam logic [15:0] RST_SHADOW_TIME     = 16'd400;
	localparam logic [1:0]  RST_MOTOR_FLIP      = 2'd2;

	typedef struct packed {
		logic [9:0]  left_threshold;
		logic [9:0]  right_threshold;
		logic [9:0]  dark_level;
		logic [9:0]  stop_distance;
		logic [15:0] corner_time;
		logic [15:0] finish_time;
		logic [15:0] shadow_time;
		logic [1:0]  motor_flip;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  left_sample;
		logic [9:0]  right_sample;
		logic [9:0]  light_sample;
		logic [9:0]  distance_cm;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct packed {
		side_t       track_side;
		logic [31:0] side_since;
		logic [31:0] both_since;
		logic [31:0] dark_since;
		logic [31:0] last_beep;
		logic        armed;
		logic        finished;
	} state_t;

	typedef struct packed {
		motor_cmd_t   left_cmd;
		motor_cmd_t   right_cmd;
		drive_state_t drive_state;
		logic         finish_tone;
		logic         warning_tone;
	} result_t;

	// Left trim is 100 percent: duties as commanded
	function automatic logic [7:0] left_mag(input motor_cmd_t cmd);
		logic [7:0] m;
		case (cmd)
			CMD_CRUISE:    m = 8'd130;
			CMD_SLOW:      m = 8'd30;
			CMD_FAST:      m = 8'd230;
			CMD_PIVOT_FWD: m = 8'd170;
			CMD_PIVOT_REV: m = 8'd170;
			default:       m = 8'd0;
		endcase
		return m;
	endfunction

	// Right trim is 70 percent, truncated toward zero
	function automatic logic [7:0] right_mag(input motor_cmd_t cmd);
		logic [7:0] m;
		case (cmd)
			CMD_CRUISE:    m = 8'd91;
			CMD_SLOW:      m = 8'd21;
			CMD_FAST:      m = 8'd161;
			CMD_PIVOT_FWD: m = 8'd119;
			CMD_PIVOT_REV: m = 8'd119;
			default:       m = 8'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/lts_motor.sv =====
`timescale 1ns / 1ps

module lts_motor (
	input  lts_pkg::motor_cmd_t cmd,
	input  logic                flip,
	input  logic                right_trim,
	output logic                forward,
	output logic [7:0]          duty
);
	import lts_pkg::*;

	logic [7:0] mag;
	logic       rev;

	always_comb begin
		mag = right_trim ? right_mag(cmd) : left_mag(cmd);
		rev = (cmd == CMD_PIVOT_REV);
		// a zero command stays forward whatever the flip
		forward = (mag == 8'd0) ? 1'b1 : ~(rev ^ flip);
		duty = mag;
	end

endmodule

// ===== hw/rtl/lts_core.sv =====
`timescale 1ns / 1ps

module lts_core (
	input  lts_pkg::cfg_t    cfg,
	input  lts_pkg::sample_t smp,
	input  lts_pkg::state_t  cur,
	output lts_pkg::state_t  nxt,
	output lts_pkg::result_t res
);
	import lts_pkg::*;

	logic  lb;
	logic  rb;
	logic  both_black;
	logic  shadowed;
	logic  obstacle;
	logic  fin_hit;
	logic  corner;
	logic  stopped;
	side_t side;

	always_comb begin
		nxt = cur;
		res.left_cmd = CMD_STOP;
		res.right_cmd = CMD_STOP;
		res.drive_state = DRIVE_RUNNING;
		res.finish_tone = 1'b0;
		res.warning_tone = 1'b0;

		lb = smp.left_sample > cfg.left_threshold;
		rb = smp.right_sample > cfg.right_threshold;
		both_black = lb && rb;

		// zero marks an unset timer
		if (smp.light_sample > cfg.dark_level) begin
			nxt.dark_since = (cur.dark_since == 32'd0) ? smp.time_ms : cur.dark_since;
		end else begin
			nxt.dark_since = 32'd0;
		end
		shadowed = (nxt.dark_since != 32'd0) &&
			((smp.time_ms - nxt.dark_since) > {16'd0, cfg.shadow_time});

		nxt.armed = cur.armed | ~both_black;
		fin_hit = 1'b0;
		if (nxt.armed && !cur.finished) begin
			if (!both_black) begin
				nxt.both_since = 32'd0;
			end else begin
				nxt.both_since = (cur.both_since == 32'd0) ? smp.time_ms : cur.both_since;
				fin_hit = (smp.time_ms - nxt.both_since) > {16'd0, cfg.finish_time};
			end
		end
		nxt.finished = cur.finished | fin_hit;
		res.finish_tone = fin_hit;

		obstacle = smp.distance_cm < cfg.stop_distance;
		side = SIDE_NONE;
		corner = 1'b0;
		if (nxt.finished) begin
			res.drive_state = DRIVE_FINISH;
		end else if (obstacle) begin
			res.drive_state = DRIVE_OBSTACLE;
		end else if (shadowed) begin
			res.drive_state = DRIVE_SHADOW;
		end else if (!nxt.armed) begin
			res.drive_state = DRIVE_WAITING;
		end else begin
			res.drive_state = DRIVE_RUNNING;
			if (lb && !rb) begin
				side = SIDE_LEFT;
			end else if (rb && !lb) begin
				side = SIDE_RIGHT;
			end else if (both_black) begin
				side = cur.track_side;
			end
			if (side != cur.track_side) begin
				nxt.track_side = side;
				nxt.side_since = smp.time_ms;
			end
			corner = (smp.time_ms - nxt.side_since) > {16'd0, cfg.corner_time};
			case (side)
				SIDE_LEFT: begin
					res.left_cmd = corner ? CMD_PIVOT_REV : CMD_SLOW;
					res.right_cmd = corner ? CMD_PIVOT_FWD : CMD_FAST;
				end
				SIDE_RIGHT: begin
					res.left_cmd = corner ? CMD_PIVOT_FWD : CMD_FAST;
					res.right_cmd = corner ? CMD_PIVOT_REV : CMD_SLOW;
				end
				default: begin
					res.left_cmd = CMD_CRUISE;
					res.right_cmd = CMD_CRUISE;
				end
			endcase
		end

		// stop ticks hold the corner timer at now and may beep
		stopped = !nxt.finished && (obstacle || shadowed);
		if (stopped) begin
			if ((smp.time_ms - cur.last_beep) > BEEP_GAP) begin
				nxt.last_beep = smp.time_ms;
				res.warning_tone = 1'b1;
			end
			nxt.side_since = smp.time_ms;
		end
	end

endmodule

// ===== hw/rtl/line_tracer_steering_controller_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    left_sample, right_sample, light_sample,
//                                 distance_cm, time_ms
// out      out_valid / out_ready  left_forward, left_duty, right_forward,
//                                 right_duty, drive_state, finish_tone, warning_tone
// cfg      cfg_write              cfg_index, cfg_data (no wait, no read-back)
//
// One item per cycle while the output is not stalled: an item is held in the input
// register, then the state update and motor decode run in one pass into the result register.
// out_valid rises when the item moves from the input register into the result register.
// Reset loads the register defaults and clears the steering state and flags.
// A stalled output holds its item; the input register still refills whenever
// the result register is free or being taken in the same cycle.

module line_tracer_steering_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  left_sample,
	input  logic [9:0]  right_sample,
	input  logic [9:0]  light_sample,
	input  logic [9:0]  distance_cm,
	input  logic [31:0] time_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        left_forward,
	output logic [7:0]  left_duty,
	output logic        right_forward,
	output logic [7:0]  right_duty,
	output logic [2:0]  drive_state,
	output logic        finish_tone,
	output logic        warning_tone,
	input  logic        cfg_write,
	input  logic [lts_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [lts_pkg::CfgDataW-1:0]  cfg_data
);
	import lts_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res;
	logic    advance;
	logic    lf_c;
	logic    rf_c;
	logic [7:0] ld_c;
	logic [7:0] rd_c;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_threshold  <= RST_LEFT_THRESHOLD;
			cfg_q.right_threshold <= RST_RIGHT_THRESHOLD;
			cfg_q.dark_level      <= RST_DARK_LEVEL;
			cfg_q.stop_distance   <= RST_STOP_DISTANCE;
			cfg_q.corner_time     <= RST_CORNER_TIME;
			cfg_q.finish_time     <= RST_FINISH_TIME;
			cfg_q.shadow_time     <= RST_SHADOW_TIME;
			cfg_q.motor_flip      <= RST_MOTOR_FLIP;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_LEFT_THRESHOLD:  cfg_q.left_threshold  <= cfg_data[9:0];
				REG_RIGHT_THRESHOLD: cfg_q.right_threshold <= cfg_data[9:0];
				REG_DARK_LEVEL:      cfg_q.dark_level      <= cfg_data[9:0];
				REG_STOP_DISTANCE:   cfg_q.stop_distance   <= cfg_data[9:0];
				REG_CORNER_TIME:     cfg_q.corner_time     <= cfg_data;
				REG_FINISH_TIME:     cfg_q.finish_time     <= cfg_data;
				REG_SHADOW_TIME:     cfg_q.shadow_time     <= cfg_data;
				REG_MOTOR_FLIP:      cfg_q.motor_flip      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_s1.left_sample  <= left_sample;
			smp_s1.right_sample <= right_sample;
			smp_s1.light_sample <= light_sample;
			smp_s1.distance_cm  <= distance_cm;
			smp_s1.time_ms      <= time_ms;
		end
	end

	lts_core u_core (
		.cfg (cfg_q),
		.smp (smp_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res)
	);

	lts_motor u_left (
		.cmd        (res.left_cmd),
		.flip       (cfg_q.motor_flip[1]),
		.right_trim (1'b0),
		.forward    (lf_c),
		.duty       (ld_c)
	);

	lts_motor u_right (
		.cmd        (res.right_cmd),
		.flip       (cfg_q.motor_flip[0]),
		.right_trim (1'b1),
		.forward    (rf_c),
		.duty       (rd_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_forward  <= lf_c;
			left_duty     <= ld_c;
			right_forward <= rf_c;
			right_duty    <= rd_c;
			drive_state   <= res.drive_state;
			finish_tone   <= res.finish_tone;
			warning_tone  <= res.warning_tone;
		end
	end

endmodule
